// ----- rtl/jbc_pkg.sv -----
// jbc_pkg: shared constants, codes and control structs for joint_box_and_centroid
// used by jbc_ctrl, jbc_dp, jbc_div and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jbc_pkg;

	localparam int DEF_MAX_JOINTS = 32;
	localparam int DEF_COORD_BITS = 24;

	localparam int AXES       = 3;
	localparam int ID_W       = 5;
	localparam int CONF_W     = 9;
	localparam int BOX_W      = 16;
	localparam int SRC_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int FRAC_BITS  = 8;
	localparam int FRAC_ROUND = 255;
	localparam int TRUNK_N    = 4;
	localparam int BOX_EXT_W  = 34;

	localparam int signed BOX_POS_LO = -32768;
	localparam int signed BOX_POS_HI = 32767;
	localparam int signed BOX_EXT_HI = 65535;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_D        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TORSO          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHOULDER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHOULDER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_HIP       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HIP      = 3'd6;

	// register reset values
	localparam logic [CONF_W-1:0] RST_THRESHOLD      = 9'd128;
	localparam logic [ID_W-1:0]   RST_TORSO          = 5'd0;
	localparam logic [ID_W-1:0]   RST_LEFT_SHOULDER  = 5'd1;
	localparam logic [ID_W-1:0]   RST_RIGHT_SHOULDER = 5'd2;
	localparam logic [ID_W-1:0]   RST_LEFT_HIP       = 5'd3;
	localparam logic [ID_W-1:0]   RST_RIGHT_HIP      = 5'd4;

	// centre source codes
	localparam logic [SRC_W-1:0] SRC_TORSO = 2'd0;
	localparam logic [SRC_W-1:0] SRC_TRUNK = 2'd1;
	localparam logic [SRC_W-1:0] SRC_ALL   = 2'd2;
	localparam logic [SRC_W-1:0] SRC_NONE  = 2'd3;

	typedef struct packed {
		logic run;
		logic div_start;
		logic emit;
	} jbc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} jbc_stat_t;

endpackage

`default_nettype wire

// ----- rtl/jbc_div.sv -----
// jbc_div: three-lane restoring divider, one quotient bit per cycle per lane
// signed dividends over a shared unsigned divisor; uses jbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module jbc_div #(
	parameter int DIVIDEND_W = 29,
	parameter int DIVISOR_W  = 6,
	parameter int QUOT_W     = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [DIVIDEND_W-1:0] dividend [jbc_pkg::AXES],
	input  wire logic        [DIVISOR_W-1:0]  divisor,
	output logic signed      [QUOT_W-1:0]     quot [jbc_pkg::AXES],
	output logic                              done
);
	import jbc_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIVISOR_W-1:0]   den_q;
	logic [DIVIDEND_W-1:0]  mag_q [AXES];
	logic [DIVISOR_W-1:0]   rem_q [AXES];
	logic                   neg_q [AXES];
	logic [DIVISOR_W:0]     trial [AXES];
	logic [DIVISOR_W:0]     diff  [AXES];
	logic                   fits  [AXES];
	logic [DIVIDEND_W-1:0]  sq    [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			trial[i] = {rem_q[i], mag_q[i][DIVIDEND_W-1]};
			diff[i]  = trial[i] - {1'b0, den_q};
			fits[i]  = trial[i] >= {1'b0, den_q};
			sq[i]    = neg_q[i] ? (~mag_q[i] + 1'b1) : mag_q[i];
			quot[i]  = sq[i][QUOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			for (int i = 0; i < AXES; i++) begin
				neg_q[i] <= dividend[i][DIVIDEND_W-1];
				mag_q[i] <= dividend[i][DIVIDEND_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < AXES; i++) begin
				mag_q[i] <= {mag_q[i][DIVIDEND_W-2:0], fits[i]};
				rem_q[i] <= fits[i] ? diff[i][DIVISOR_W-1:0] : trial[i][DIVISOR_W-1:0];
			end
		end
	end

	assign done = done_q;

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0) && !done_q)
		else $error("divider busy with spent bit counter");

endmodule

`default_nettype wire

// ----- rtl/jbc_ctrl.sv -----
// jbc_ctrl: sequencer for joint_box_and_centroid
// accepts joints, then starts the divide and hands the result to the output register; uses jbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module jbc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	input  wire jbc_pkg::jbc_stat_t stat,
	output jbc_pkg::jbc_cmd_t       cmd,
	output logic                    in_ready
);
	import jbc_pkg::*;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_valid && in_last) state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.run       = (state_q == ST_RUN);
		cmd.div_start = (state_q == ST_START);
		cmd.emit      = (state_q == ST_EMIT) && stat.out_free;
	end

	assign in_ready = cmd.run;

endmodule

`default_nettype wire

// ----- rtl/jbc_dp.sv -----
// jbc_dp: configuration registers, joint accumulators, result logic and output register
// instantiates jbc_div; driven by jbc_ctrl commands; uses jbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module jbc_dp #(
	parameter int MAX_JOINTS = jbc_pkg::DEF_MAX_JOINTS,
	parameter int COORD_BITS = jbc_pkg::DEF_COORD_BITS,
	localparam int CW = $clog2(MAX_JOINTS + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire jbc_pkg::jbc_cmd_t                  cmd,
	output jbc_pkg::jbc_stat_t                      stat,
	input  wire logic                               in_valid,
	input  wire logic [jbc_pkg::ID_W-1:0]           joint_id,
	input  wire logic signed [COORD_BITS-1:0]       pos_x,
	input  wire logic signed [COORD_BITS-1:0]       pos_y,
	input  wire logic signed [COORD_BITS-1:0]       pos_z,
	input  wire logic [jbc_pkg::CONF_W-1:0]         confidence,
	input  wire logic                               cfg_we,
	input  wire logic [jbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [jbc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic signed [COORD_BITS-1:0]            center_x,
	output logic signed [COORD_BITS-1:0]            center_y,
	output logic signed [COORD_BITS-1:0]            center_z,
	output logic [jbc_pkg::SRC_W-1:0]               center_source,
	output logic signed [jbc_pkg::BOX_W-1:0]        box_left,
	output logic signed [jbc_pkg::BOX_W-1:0]        box_top,
	output logic [jbc_pkg::BOX_W-1:0]               box_width,
	output logic [jbc_pkg::BOX_W-1:0]               box_height,
	output logic                                    box_valid,
	output logic [CW-1:0]                           used_count
);
	import jbc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int SW = COORD_BITS + $clog2(MAX_JOINTS);
	localparam int TW = COORD_BITS + 2;
	localparam int EW = BOX_EXT_W;
	localparam logic signed [CB-1:0] POS_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] NEG_MIN = {1'b1, {(CB-1){1'b0}}};

	// configuration
	logic [CONF_W-1:0] thr_q;
	logic              three_d_q;
	logic [ID_W-1:0]   torso_id_q;
	logic [ID_W-1:0]   trunk_id_q [TRUNK_N];

	// accumulators
	logic signed [CB-1:0] min_q   [2];
	logic signed [CB-1:0] max_q   [2];
	logic signed [SW-1:0] sum_q   [AXES];
	logic signed [CB-1:0] torso_q [AXES];
	logic signed [TW-1:0] tsum_q  [AXES];
	logic [CW-1:0]        count_q;
	logic                 torso_seen_q;
	logic [TRUNK_N-1:0]   mask_q;

	logic signed [CB-1:0] p     [AXES];
	logic signed [TW-1:0] tp    [AXES];
	logic signed [TW-1:0] tmul  [AXES];
	logic [TRUNK_N-1:0]   hits;
	logic [2:0]           nhit;
	logic                 qual;
	logic                 torso_hit;

	// result
	logic signed [CB-1:0] quot   [AXES];
	logic                 div_done;
	logic signed [TW-1:0] tround [AXES];
	logic signed [CB-1:0] cen_d  [AXES];
	logic [SRC_W-1:0]     src_d;
	logic signed [EW-1:0] lo_ext [2];
	logic signed [EW-1:0] ex_ext [2];
	logic signed [BOX_W-1:0] pos_d [2];
	logic [BOX_W-1:0]     ext_d [2];
	logic                 bv_d;

	logic                 out_valid_q;
	logic signed [CB-1:0] cen_q [AXES];
	logic [SRC_W-1:0]     src_q;
	logic signed [BOX_W-1:0] pos_q [2];
	logic [BOX_W-1:0]     ext_q [2];
	logic                 bv_q;
	logic [CW-1:0]        used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= RST_THRESHOLD;
			three_d_q     <= 1'b0;
			torso_id_q    <= RST_TORSO;
			trunk_id_q[0] <= RST_LEFT_SHOULDER;
			trunk_id_q[1] <= RST_RIGHT_SHOULDER;
			trunk_id_q[2] <= RST_LEFT_HIP;
			trunk_id_q[3] <= RST_RIGHT_HIP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:      thr_q         <= cfg_data;
				REG_THREE_D:        three_d_q     <= cfg_data[0];
				REG_TORSO:          torso_id_q    <= cfg_data[ID_W-1:0];
				REG_LEFT_SHOULDER:  trunk_id_q[0] <= cfg_data[ID_W-1:0];
				REG_RIGHT_SHOULDER: trunk_id_q[1] <= cfg_data[ID_W-1:0];
				REG_LEFT_HIP:       trunk_id_q[2] <= cfg_data[ID_W-1:0];
				REG_RIGHT_HIP:      trunk_id_q[3] <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	assign p[0] = pos_x;
	assign p[1] = pos_y;
	assign p[2] = pos_z;

	always_comb begin
		qual = cmd.run && in_valid && (confidence >= thr_q) && (count_q < CW'(MAX_JOINTS));
		torso_hit = (joint_id == torso_id_q);
		for (int k = 0; k < TRUNK_N; k++) begin
			hits[k] = (joint_id == trunk_id_q[k]) && !mask_q[k];
		end
		nhit = {2'b00, hits[0]} + {2'b00, hits[1]} + {2'b00, hits[2]} + {2'b00, hits[3]};
		for (int i = 0; i < AXES; i++) begin
			tp[i] = TW'(p[i]);
			unique case (nhit)
				3'd0:    tmul[i] = '0;
				3'd1:    tmul[i] = tp[i];
				3'd2:    tmul[i] = tp[i] <<< 1;
				3'd3:    tmul[i] = tp[i] + (tp[i] <<< 1);
				default: tmul[i] = tp[i] <<< 2;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				min_q[i] <= POS_MAX;
				max_q[i] <= NEG_MIN;
			end
			for (int i = 0; i < AXES; i++) begin
				sum_q[i]   <= '0;
				torso_q[i] <= '0;
				tsum_q[i]  <= '0;
			end
			count_q      <= '0;
			torso_seen_q <= 1'b0;
			mask_q       <= '0;
		end else if (cmd.emit) begin
			for (int i = 0; i < 2; i++) begin
				min_q[i] <= POS_MAX;
				max_q[i] <= NEG_MIN;
			end
			for (int i = 0; i < AXES; i++) begin
				sum_q[i]   <= '0;
				torso_q[i] <= '0;
				tsum_q[i]  <= '0;
			end
			count_q      <= '0;
			torso_seen_q <= 1'b0;
			mask_q       <= '0;
		end else if (qual) begin
			for (int i = 0; i < 2; i++) begin
				if (p[i] < min_q[i]) min_q[i] <= p[i];
				if (p[i] > max_q[i]) max_q[i] <= p[i];
			end
			for (int i = 0; i < AXES; i++) begin
				sum_q[i]  <= sum_q[i] + SW'(p[i]);
				tsum_q[i] <= tsum_q[i] + tmul[i];
				if (torso_hit) torso_q[i] <= p[i];
			end
			count_q <= count_q + 1'b1;
			if (torso_hit) torso_seen_q <= 1'b1;
			mask_q <= mask_q | hits;
		end
	end

	jbc_div #(
		.DIVIDEND_W (SW),
		.DIVISOR_W  (CW),
		.QUOT_W     (CB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.quot     (quot),
		.done     (div_done)
	);

	always_comb begin
		if (torso_seen_q) begin
			src_d = SRC_TORSO;
		end else if (mask_q == {TRUNK_N{1'b1}}) begin
			src_d = SRC_TRUNK;
		end else if (count_q != '0) begin
			src_d = SRC_ALL;
		end else begin
			src_d = SRC_NONE;
		end
		for (int i = 0; i < AXES; i++) begin
			// divide by four, truncating toward zero
			tround[i] = tsum_q[i] + (tsum_q[i][TW-1] ? TW'(3) : TW'(0));
			unique case (src_d)
				SRC_TORSO: cen_d[i] = torso_q[i];
				SRC_TRUNK: cen_d[i] = tround[i][TW-1:2];
				SRC_ALL:   cen_d[i] = quot[i];
				default:   cen_d[i] = '0;
			endcase
		end
		bv_d = !three_d_q && (count_q != '0);
		for (int i = 0; i < 2; i++) begin
			lo_ext[i] = EW'(min_q[i]) >>> FRAC_BITS;
			ex_ext[i] = (EW'(max_q[i]) - EW'(min_q[i]) + EW'(FRAC_ROUND)) >>> FRAC_BITS;
			if (!bv_d) begin
				pos_d[i] = '0;
			end else if (lo_ext[i] < EW'(BOX_POS_LO)) begin
				pos_d[i] = BOX_W'(BOX_POS_LO);
			end else if (lo_ext[i] > EW'(BOX_POS_HI)) begin
				pos_d[i] = BOX_W'(BOX_POS_HI);
			end else begin
				pos_d[i] = lo_ext[i][BOX_W-1:0];
			end
			if (!bv_d || ex_ext[i] < 0) begin
				ext_d[i] = '0;
			end else if (ex_ext[i] > EW'(BOX_EXT_HI)) begin
				ext_d[i] = BOX_W'(BOX_EXT_HI);
			end else begin
				ext_d[i] = ex_ext[i][BOX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < AXES; i++) cen_q[i] <= cen_d[i];
			for (int i = 0; i < 2; i++) begin
				pos_q[i] <= pos_d[i];
				ext_q[i] <= ext_d[i];
			end
			src_q  <= src_d;
			bv_q   <= bv_d;
			used_q <= count_q;
		end
	end

	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign center_x      = cen_q[0];
	assign center_y      = cen_q[1];
	assign center_z      = cen_q[2];
	assign center_source = src_q;
	assign box_left      = pos_q[0];
	assign box_top       = pos_q[1];
	assign box_width     = ext_q[0];
	assign box_height    = ext_q[1];
	assign box_valid     = bv_q;
	assign used_count    = used_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOINTS))
		else $error("joint count beyond limit");

	a_box_needs_joint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bv_q |-> (src_q != SRC_NONE) && (used_q != '0))
		else $error("valid box with no qualifying joint");

endmodule

`default_nettype wire

// ----- rtl/joint_box_and_centroid.sv -----
// joint_box_and_centroid: bounding box and centroid of one skeleton, one joint per item
// sequence: after the last joint is taken the sequencer starts the bit-serial centroid divider,
// waits for it to finish and registers the result once the output register is free
// throughput: one joint item per cycle while s_axis_tready is high; it falls after a last joint
// reset: arst_n clears the sequencer, accumulators and output valid, and loads register defaults
// depends on jbc_pkg, jbc_ctrl, jbc_dp, jbc_div
`timescale 1ns / 1ps
`default_nettype none

module joint_box_and_centroid #(
	parameter int MAX_JOINTS = jbc_pkg::DEF_MAX_JOINTS,
	parameter int COORD_BITS = jbc_pkg::DEF_COORD_BITS,
	localparam int CW    = $clog2(MAX_JOINTS + 1),
	localparam int IN_W  = ((jbc_pkg::ID_W + 3 * COORD_BITS + jbc_pkg::CONF_W + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_BITS + 4 * jbc_pkg::BOX_W + CW + 7) / 8) * 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// joint_id, pos_x, pos_y, pos_z, confidence, zero fill
	input  wire logic [IN_W-1:0]                    s_axis_tdata,
	// last_joint
	input  wire logic                               s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// center_x, center_y, center_z, box_left, box_top, box_width, box_height,
	// used_count, zero fill
	output logic [OUT_W-1:0]                        m_axis_tdata,
	// center_source, box_valid
	output logic [2:0]                              m_axis_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [jbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [jbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jbc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int X_LO = ID_W;
	localparam int Y_LO = ID_W + CB;
	localparam int Z_LO = ID_W + 2 * CB;
	localparam int C_LO = ID_W + 3 * CB;

	jbc_cmd_t cmd;
	jbc_stat_t stat;

	logic signed [CB-1:0]    center_x;
	logic signed [CB-1:0]    center_y;
	logic signed [CB-1:0]    center_z;
	logic [SRC_W-1:0]        center_source;
	logic signed [BOX_W-1:0] box_left;
	logic signed [BOX_W-1:0] box_top;
	logic [BOX_W-1:0]        box_width;
	logic [BOX_W-1:0]        box_height;
	logic                    box_valid;
	logic [CW-1:0]           used_count;

	jbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	jbc_dp #(
		.MAX_JOINTS (MAX_JOINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_valid      (s_axis_tvalid),
		.joint_id      (s_axis_tdata[ID_W-1:0]),
		.pos_x         (s_axis_tdata[X_LO +: CB]),
		.pos_y         (s_axis_tdata[Y_LO +: CB]),
		.pos_z         (s_axis_tdata[Z_LO +: CB]),
		.confidence    (s_axis_tdata[C_LO +: CONF_W]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.center_source (center_source),
		.box_left      (box_left),
		.box_top       (box_top),
		.box_width     (box_width),
		.box_height    (box_height),
		.box_valid     (box_valid),
		.used_count    (used_count)
	);

	assign m_axis_tdata = OUT_W'({used_count, box_height, box_width, box_top, box_left,
		center_z, center_y, center_x});
	assign m_axis_tuser = {box_valid, center_source};

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("joint taken while skeleton result pending");

	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result raised without a finishing pass");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for joint_box_and_centroid: streams skeletons of joints and checks each summary
// result field by field against a scoreboard that tracks the box, centroid and counts
// depends on jbc_pkg and the joint_box_and_centroid rtl
`timescale 1ns / 1ps

typedef struct {
	logic signed [jbc_pkg::DEF_COORD_BITS-1:0] center_x;
	logic signed [jbc_pkg::DEF_COORD_BITS-1:0] center_y;
	logic signed [jbc_pkg::DEF_COORD_BITS-1:0] center_z;
	logic [jbc_pkg::SRC_W-1:0] center_source;
	logic signed [jbc_pkg::BOX_W-1:0] box_left;
	logic signed [jbc_pkg::BOX_W-1:0] box_top;
	logic [jbc_pkg::BOX_W-1:0] box_width;
	logic [jbc_pkg::BOX_W-1:0] box_height;
	logic box_valid;
	logic [5:0] used_count;
} skeleton_summary_t;

class skeleton_scoreboard;
	bit [jbc_pkg::CONF_W-1:0] threshold;
	bit three_d;
	bit [jbc_pkg::ID_W-1:0] torso_id;
	bit [jbc_pkg::ID_W-1:0] trunk_id [jbc_pkg::TRUNK_N];
	longint min_xy [2];
	longint max_xy [2];
	longint coord_sum [3];
	longint torso_pos [3];
	longint trunk_sum [3];
	int joint_count;
	bit torso_seen;
	bit [jbc_pkg::TRUNK_N-1:0] trunk_mask;
	skeleton_summary_t expected_summaries [$];
	int errors;

	function new();
		threshold = jbc_pkg::RST_THRESHOLD;
		three_d = 1'b0;
		torso_id = jbc_pkg::RST_TORSO;
		trunk_id[0] = jbc_pkg::RST_LEFT_SHOULDER;
		trunk_id[1] = jbc_pkg::RST_RIGHT_SHOULDER;
		trunk_id[2] = jbc_pkg::RST_LEFT_HIP;
		trunk_id[3] = jbc_pkg::RST_RIGHT_HIP;
		errors = 0;
		clear_sums();
	endfunction

	function void clear_sums();
		for (int a = 0; a < 2; a++) begin
			min_xy[a] = (longint'(1) <<< (jbc_pkg::DEF_COORD_BITS - 1)) - 1;
			max_xy[a] = -(longint'(1) <<< (jbc_pkg::DEF_COORD_BITS - 1));
		end
		for (int a = 0; a < 3; a++) begin
			coord_sum[a] = 0;
			torso_pos[a] = 0;
			trunk_sum[a] = 0;
		end
		joint_count = 0;
		torso_seen = 1'b0;
		trunk_mask = '0;
	endfunction

	function void write_reg(bit [jbc_pkg::CFG_IDX_W-1:0] idx, bit [jbc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			jbc_pkg::REG_THRESHOLD: threshold = data;
			jbc_pkg::REG_THREE_D: three_d = data[0];
			jbc_pkg::REG_TORSO: torso_id = data[4:0];
			jbc_pkg::REG_LEFT_SHOULDER: trunk_id[0] = data[4:0];
			jbc_pkg::REG_RIGHT_SHOULDER: trunk_id[1] = data[4:0];
			jbc_pkg::REG_LEFT_HIP: trunk_id[2] = data[4:0];
			jbc_pkg::REG_RIGHT_HIP: trunk_id[3] = data[4:0];
			default: ;
		endcase
	endfunction

	function longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function void note_joint(bit [4:0] id, logic signed [23:0] x, logic signed [23:0] y,
			logic signed [23:0] z, bit [8:0] conf, bit last);
		longint pos [3];
		skeleton_summary_t r;
		pos[0] = x;
		pos[1] = y;
		pos[2] = z;
		if (conf >= threshold && joint_count < jbc_pkg::DEF_MAX_JOINTS) begin
			for (int a = 0; a < 2; a++) begin
				if (pos[a] < min_xy[a]) min_xy[a] = pos[a];
				if (pos[a] > max_xy[a]) max_xy[a] = pos[a];
			end
			for (int a = 0; a < 3; a++)
				coord_sum[a] += pos[a];
			joint_count++;
			if (id == torso_id) begin
				for (int a = 0; a < 3; a++)
					torso_pos[a] = pos[a];
				torso_seen = 1'b1;
			end
			// each trunk slot keeps its first qualifying joint
			for (int k = 0; k < jbc_pkg::TRUNK_N; k++) begin
				if (id == trunk_id[k] && !trunk_mask[k]) begin
					for (int a = 0; a < 3; a++)
						trunk_sum[a] += pos[a];
					trunk_mask[k] = 1'b1;
				end
			end
		end
		if (!last)
			return;
		r.center_x = '0;
		r.center_y = '0;
		r.center_z = '0;
		r.box_left = '0;
		r.box_top = '0;
		r.box_width = '0;
		r.box_height = '0;
		r.box_valid = 1'b0;
		r.used_count = 6'(joint_count);
		if (torso_seen) begin
			r.center_source = jbc_pkg::SRC_TORSO;
			r.center_x = 24'(torso_pos[0]);
			r.center_y = 24'(torso_pos[1]);
			r.center_z = 24'(torso_pos[2]);
		end else if (&trunk_mask) begin
			r.center_source = jbc_pkg::SRC_TRUNK;
			r.center_x = 24'(trunk_sum[0] / 4);
			r.center_y = 24'(trunk_sum[1] / 4);
			r.center_z = 24'(trunk_sum[2] / 4);
		end else if (joint_count > 0) begin
			r.center_source = jbc_pkg::SRC_ALL;
			r.center_x = 24'(coord_sum[0] / joint_count);
			r.center_y = 24'(coord_sum[1] / joint_count);
			r.center_z = 24'(coord_sum[2] / joint_count);
		end else begin
			r.center_source = jbc_pkg::SRC_NONE;
		end
		if (!three_d && joint_count > 0) begin
			r.box_valid = 1'b1;
			r.box_left = 16'(clamp(min_xy[0] >>> 8, -32768, 32767));
			r.box_top = 16'(clamp(min_xy[1] >>> 8, -32768, 32767));
			r.box_width = 16'(clamp((max_xy[0] - min_xy[0] + 255) / 256, 0, 65535));
			r.box_height = 16'(clamp((max_xy[1] - min_xy[1] + 255) / 256, 0, 65535));
		end
		expected_summaries.insert(expected_summaries.size(), r);
		clear_sums();
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_summary(skeleton_summary_t got);
		skeleton_summary_t want;
		if (expected_summaries.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual center_x %0d used_count %0d",
				$time, got.center_x, got.used_count);
			errors++;
			return;
		end
		want = expected_summaries.pop_front();
		compare_field("center_x", want.center_x, got.center_x);
		compare_field("center_y", want.center_y, got.center_y);
		compare_field("center_z", want.center_z, got.center_z);
		compare_field("center_source", want.center_source, got.center_source);
		compare_field("box_left", want.box_left, got.box_left);
		compare_field("box_top", want.box_top, got.box_top);
		compare_field("box_width", want.box_width, got.box_width);
		compare_field("box_height", want.box_height, got.box_height);
		compare_field("box_valid", want.box_valid, got.box_valid);
		compare_field("used_count", want.used_count, got.used_count);
	endfunction
endclass

module testbench;
	import jbc_pkg::*;

	localparam int COORD_W = DEF_COORD_BITS;
	localparam int CNT_W = $clog2(DEF_MAX_JOINTS + 1);
	localparam int IN_W = ((ID_W + 3 * COORD_W + CONF_W + 7) / 8) * 8;
	localparam int OUT_W = ((3 * COORD_W + 4 * BOX_W + CNT_W + 7) / 8) * 8;
	localparam int DRAIN_CYCLES = COORD_W + $clog2(DEF_MAX_JOINTS) + 3 + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	skeleton_scoreboard sb;
	int tx_idle_pct = 26;
	int rx_idle_pct = 87;
	int rx_hold = 0;
	int items_sent = 0;

	joint_box_and_centroid uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin : result_side
		skeleton_summary_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.center_x = m_axis_tdata[23:0];
			got.center_y = m_axis_tdata[47:24];
			got.center_z = m_axis_tdata[71:48];
			got.box_left = m_axis_tdata[87:72];
			got.box_top = m_axis_tdata[103:88];
			got.box_width = m_axis_tdata[119:104];
			got.box_height = m_axis_tdata[135:120];
			got.used_count = m_axis_tdata[141:136];
			got.center_source = m_axis_tuser[1:0];
			got.box_valid = m_axis_tuser[2];
			sb.check_summary(got);
		end
		// long hold-off lets the block back up into its input
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return 24'($urandom);
			6, 7, 8: return 24'($urandom_range(4000) - 2000);
			default: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
		endcase
	endfunction

	task automatic send_joint(input logic [4:0] id, input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z, input logic [8:0] conf, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= IN_W'({$urandom, $urandom, $urandom});
			s_axis_tlast <= 1'($urandom_range(1));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, conf, z, y, x, id};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_joint(id, x, y, z, conf, last);
		items_sent++;
	endtask

	task automatic run_skeletons(input int target);
		logic [4:0] ids [$];
		logic [4:0] t;
		logic [8:0] conf;
		bit [31:0] taken;
		int kind, n, k;
		while (items_sent < target) begin
			ids.delete();
			taken = '0;
			kind = $urandom_range(99);
			if (kind < 15) begin
				// noise: repeated ids, any confidence, sometimes past the joint limit
				n = ($urandom_range(3) == 0) ? $urandom_range(45, 33) : $urandom_range(12, 1);
				repeat (n) ids.insert(ids.size(), 5'($urandom_range(31)));
			end else begin
				n = $urandom_range(16, 1);
				if (kind < 45) begin
					ids.insert(ids.size(), sb.torso_id);
					taken[sb.torso_id] = 1'b1;
				end else if (kind < 80) begin
					taken[sb.torso_id] = 1'b1;
					for (int s = 0; s < TRUNK_N; s++) begin
						if (!taken[sb.trunk_id[s]]) begin
							ids.insert(ids.size(), sb.trunk_id[s]);
							taken[sb.trunk_id[s]] = 1'b1;
						end
					end
				end
				while (ids.size() < n) begin
					t = 5'($urandom_range(31));
					if (!taken[t]) begin
						ids.insert(ids.size(), t);
						taken[t] = 1'b1;
					end
				end
			end
			for (int j = ids.size() - 1; j > 0; j--) begin
				k = $urandom_range(j);
				t = ids[j];
				ids[j] = ids[k];
				ids[k] = t;
			end
			for (int j = 0; j < ids.size(); j++) begin
				if (kind < 15 || sb.threshold == 0)
					conf = 9'($urandom_range(511));
				else if ($urandom_range(9) != 0)
					conf = 9'($urandom_range(511, sb.threshold));
				else
					conf = 9'($urandom_range(sb.threshold - 1, 0));
				send_joint(ids[j], rand_coord(), rand_coord(), rand_coord(), conf,
					j == ids.size() - 1);
			end
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_summaries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [8:0] thr, input logic td, input logic [4:0] torso,
			input logic [4:0] ls, input logic [4:0] rs, input logic [4:0] lh, input logic [4:0] rh);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_THREE_D, CFG_DATA_W'(td));
		write_reg(REG_TORSO, CFG_DATA_W'(torso));
		write_reg(REG_LEFT_SHOULDER, CFG_DATA_W'(ls));
		write_reg(REG_RIGHT_SHOULDER, CFG_DATA_W'(rs));
		write_reg(REG_LEFT_HIP, CFG_DATA_W'(lh));
		write_reg(REG_RIGHT_HIP, CFG_DATA_W'(rh));
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing qualifies
		send_joint(5'd9, 24'h123456, 24'h800000, 24'h7fffff, 9'd127, 1'b1);
		// coordinate extremes, confidence at and above full scale, torso
		send_joint(5'd31, 24'h7fffff, 24'h800000, 24'h000100, 9'd256, 1'b0);
		send_joint(5'd5, 24'h800000, 24'h7fffff, 24'h800000, 9'd128, 1'b0);
		send_joint(5'd0, 24'h000180, 24'hfffe80, 24'h000000, 9'd511, 1'b1);
		// four trunk joints, torso below threshold, repeated shoulder
		send_joint(5'd0, 24'h000400, 24'h000400, 24'h000400, 9'd0, 1'b0);
		send_joint(5'd1, -24'sd769, 24'sd1000, -24'sd3, 9'd200, 1'b0);
		send_joint(5'd2, 24'sd255, -24'sd1, 24'sd7, 9'd128, 1'b0);
		send_joint(5'd1, 24'sd9999, 24'sd9999, 24'sd9999, 9'd255, 1'b0);
		send_joint(5'd3, -24'sd2, 24'sd513, 24'sd0, 9'd300, 1'b0);
		send_joint(5'd20, 24'sd100000, -24'sd100000, 24'sd5, 9'd129, 1'b0);
		send_joint(5'd4, 24'sd1, 24'sd2, -24'sd1, 9'd256, 1'b1);
		// repeated torso, last qualifying one wins
		send_joint(5'd0, 24'sd5000, -24'sd5000, 24'sd77, 9'd200, 1'b0);
		send_joint(5'd0, -24'sd123, 24'sd456, -24'sd789, 9'd300, 1'b0);
		send_joint(5'd0, 24'sd1, 24'sd1, 24'sd1, 9'd5, 1'b1);
		// partial trunk, negative averages truncate toward zero
		send_joint(5'd1, -24'sd5, 24'sd7, -24'sd1, 9'd128, 1'b0);
		send_joint(5'd2, -24'sd1, 24'sd0, -24'sd1, 9'd140, 1'b0);
		send_joint(5'd4, -24'sd1, 24'sd1, -24'sd2, 9'd511, 1'b0);
		send_joint(5'd30, 24'sd4, 24'sd4, 24'sd4, 9'd0, 1'b1);

		run_skeletons(125);
		wait_drained();
		configure(9'd0, 1'b1, 5'd31, 5'd7, 5'd7, 5'd7, 5'd7);
		run_skeletons(250);
		wait_drained();

		tx_idle_pct = 87;
		rx_idle_pct = 26;
		configure(9'd256, 1'b0, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14);
		run_skeletons(375);
		wait_drained();
		configure(9'($urandom_range(255, 1)), 1'b0, 5'($urandom_range(31)),
			5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
			5'($urandom_range(31)));
		run_skeletons(440);
		wait_drained();
		run_skeletons(500);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(9'd64, 1'b0, 5'd3, 5'd0, 5'd31, 5'd16, 5'd3);
		rx_hold = 500;
		run_skeletons(625);
		wait_drained();
		configure(9'd200, 1'b0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4);
		run_skeletons(750);
		wait_drained();

		if (sb.errors == 0 && sb.expected_summaries.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/jbc_pkg.sv
rtl/jbc_div.sv
rtl/jbc_ctrl.sv
rtl/jbc_dp.sv
rtl/joint_box_and_centroid.sv
sim/testbench.sv
